>>> sv/ali_pkg.sv
package ali_pkg;

   // Default list depth.
   localparam int CAPACITY_DEF = 16;

   // Width of one stored value.
   localparam int DATA_W = 32;

   // Command opcodes.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [1:0]               opcode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] match_index;
      logic [4:0] entries_now;
   } rsp_type;

endpackage

>>> sv/ali_ram.sv
module ali_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> sv/array_list_insert_front_delete_unit.sv
// Channel    | Direction | Handshake            | Payload
// request    | in        | req_valid/req_ready  | req_data  (opcode, value)
// response   | out       | rsp_valid/rsp_ready  | rsp_data  (status, match_index, entries_now)
//
// Insert at front, insert into a full list and the unused opcode go from idle straight to the done state.
// Find and delete walk the list through the single read port of the entry RAM and
// one 32-bit equality comparator, one entry per cycle; delete then moves each later
// entry down one place, one per cycle.
// Reset clears the count, the head pointer and the sequencer; the RAM is not cleared.
// A response stalled on rsp_ready holds in the output register while the next request
// is taken; only the final hand-off waits for the output register to free up.

module array_list_insert_front_delete_unit #(
   parameter int CAPACITY = ali_pkg::CAPACITY_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ali_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ali_pkg::rsp_type rsp_data
);

   import ali_pkg::*;

   // The list lives in a circular buffer. Position i of the list sits at physical
   // address (head + i) mod CAPACITY, so an insert at the front only moves the head
   // down by one and writes a single entry.
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int XW = (IW > 5) ? IW : 5;

   localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);
   localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
   localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [IW-1:0]     count_ff, count_in;
   logic [1:0]        op_ff, op_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]     wr_idx_ff, wr_idx_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic [AW-1:0]     head_dec;
   logic [IW-1:0]     cmp_idx;
   logic [XW-1:0]     pos_ext;
   logic [XW-1:0]     count_ext;

   // Maps a list position to its RAM address; the sum stays below twice the
   // capacity, so one compare and subtract wraps it.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [IW-1:0] idx);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, idx[AW-1:0]};
      if (sum >= CAP_A) begin
         sum = sum - CAP_A;
      end
      return sum[AW-1:0];
   endfunction

   assign head_dec  = (head_ff == '0) ? LAST_A : head_ff - 1'b1;
   assign cmp_idx   = rd_idx_ff - 1'b1;
   assign pos_ext   = XW'(pos_ff);
   assign count_ext = XW'(count_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      value_in     = value_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = 1'b0;
      wr_idx_in    = wr_idx_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = phys(head_ff, wr_idx_ff);
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = phys(head_ff, rd_idx_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               value_in  = req_data.value;
               pos_in    = '0;
               status_in = ST_OK;
               rd_idx_in = '0;
               wr_idx_in = '0;
               if (req_data.opcode == OP_INSERT) begin
                  // The new entry goes straight into the slot below the head.
                  if (count_ff >= CAP_I) begin
                     status_in = ST_FULL;
                  end else begin
                     head_in     = head_dec;
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = head_dec;
                     ram_wr_data = req_data.value;
                     count_in    = count_ff + 1'b1;
                  end
                  state_in = S_DONE;
               end else if (req_data.opcode == OP_DELETE ||
                            req_data.opcode == OP_FIND) begin
                  if (count_ff == '0) begin
                     status_in = ST_MISSING;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  // The unused opcode changes nothing and reports success.
                  state_in = S_DONE;
               end
            end
         end

         S_SCAN: begin
            // One read is issued per cycle; the comparator checks the entry
            // read in the cycle before.
            if (rd_idx_ff < count_ff) begin
               ram_rd_en    = 1'b1;
               rd_idx_in    = rd_idx_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end
            if (cmp_valid_ff) begin
               if (ram_rd_data == value_ff) begin
                  pos_in       = cmp_idx;
                  cmp_valid_in = 1'b0;
                  if (op_ff == OP_DELETE) begin
                     rd_idx_in = cmp_idx + 1'b1;
                     wr_idx_in = cmp_idx;
                     state_in  = S_SHIFT;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (rd_idx_ff == count_ff) begin
                  status_in = ST_MISSING;
                  state_in  = S_DONE;
               end
            end
         end

         S_SHIFT: begin
            // Each later entry is read and, in the next cycle, written one place lower.
            if (rd_idx_ff < count_ff) begin
               ram_rd_en    = 1'b1;
               rd_idx_in    = rd_idx_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end
            if (cmp_valid_ff) begin
               ram_wr_en = 1'b1;
               wr_idx_in = wr_idx_ff + 1'b1;
            end
            if (!cmp_valid_ff && rd_idx_ff >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.match_index = pos_ext[3:0];
               rsp_data_in.entries_now = count_ext[4:0];
               state_in                = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      rd_idx_ff   <= rd_idx_in;
      wr_idx_ff   <= wr_idx_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   ali_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> sv/ali_checker.sv
module ali_checker #(
   parameter int CAPACITY = ali_pkg::CAPACITY_DEF
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ali_pkg::rsp_type rsp_data
);

   import ali_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // The unit works on one request at a time.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A full report only comes with the list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         rsp_data.entries_now == 5'(CAPACITY) && rsp_data.match_index == 4'd0)
      else $error("full status with wrong count");

   // A miss never reports a position.
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_MISSING |-> rsp_data.match_index == 4'd0)
      else $error("not-found response carries an index");

   // Nothing is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind array_list_insert_front_delete_unit ali_checker #(
   .CAPACITY (CAPACITY)
) u_ali_checker (.*);
